@@ design/cone_sphere_intersect_test_assert.svh @@
// Assertion macros used by the checker file csit_checker.sv.
`ifndef CONE_SPHERE_INTERSECT_TEST_ASSERT_SVH
`define CONE_SPHERE_INTERSECT_TEST_ASSERT_SVH

// Implication checked in the same cycle, disabled during reset.
`define CSIT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Delayed implication; the delay is given by the argument n.
`define CSIT_ASSERT_DLY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("assertion failed");

`endif

@@ design/csit_pkg.sv @@
`default_nettype none
package csit_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ONE_Q14    = 16384;
  localparam int Q14_BITS   = 14;
  localparam int SQ_IN_W    = 62;
  localparam int SIN_IN_W   = 30;
  localparam int DIV_NUM_W  = 48;
  localparam int SQ62_LAT   = SQ_IN_W / 2;
  localparam int SQ30_LAT   = SIN_IN_W / 2;
  localparam int DIV_LAT    = Q14_BITS + 1;
  localparam int PIPE_LAT   = 6 + SQ62_LAT + DIV_LAT + 1 + SQ30_LAT + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_APEX_X         = 3'd0,
    REG_APEX_Y         = 3'd1,
    REG_APEX_Z         = 3'd2,
    REG_DIR_X          = 3'd3,
    REG_DIR_Y          = 3'd4,
    REG_DIR_Z          = 3'd5,
    REG_HALF_ANGLE_COS = 3'd6
  } csit_reg_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } csit_in_t;

  typedef struct packed {
    logic hit;
    logic apex_at_center;
  } csit_out_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] absdot;
    logic                 dotneg;
    logic                 zero;
    logic                 dirzero;
  } csit_side_a_t;

  typedef struct packed {
    logic dotneg;
    logic zero;
    logic dirzero;
  } csit_side_b_t;

  typedef struct packed {
    logic signed [15:0] cg;
    logic signed [15:0] ca;
    logic [14:0]        cb;
    logic               zero;
    logic               dirzero;
  } csit_side_c_t;

endpackage
`default_nettype wire

@@ design/cone_sphere_intersect_test.sv @@
// Cone/sphere overlap test. The cone (apex, axis, cosine of the half-angle) is held in
// configuration registers that may only be written while no sphere is in flight. Each
// sphere is taken when start is high and busy is low, one per clock cycle without gaps.
// Its result appears on result for exactly one cycle, marked by done;
// the receiver cannot hold it off, so every transfer must be taken when shown. The
// pipeline has six front-end stages, the three parallel 31-stage square roots, the
// 15-stage dividers, one stage for the sine operands, the 15-stage sine roots and two
// final compare stages, all fully pipelined.
`default_nettype none
module cone_sphere_intersect_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  csit_pkg::csit_in_t                    sphere,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [csit_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csit_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  done,
  output csit_pkg::csit_out_t                   result
);

  localparam int RW = csit_pkg::SQ_IN_W / 2;
  localparam int SW = csit_pkg::SIN_IN_W / 2;

  logic signed [31:0] apex [3];
  logic signed [15:0] dir [3];
  logic signed [15:0] hac;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      apex[0] <= '0;
      apex[1] <= '0;
      apex[2] <= '0;
      dir[0]  <= '0;
      dir[1]  <= '0;
      dir[2]  <= 16'sd16384;
      hac     <= -16'sd16384;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csit_pkg::REG_APEX_X:         apex[0] <= cfg_data;
        csit_pkg::REG_APEX_Y:         apex[1] <= cfg_data;
        csit_pkg::REG_APEX_Z:         apex[2] <= cfg_data;
        csit_pkg::REG_DIR_X:          dir[0]  <= cfg_data[15:0];
        csit_pkg::REG_DIR_Y:          dir[1]  <= cfg_data[15:0];
        csit_pkg::REG_DIR_Z:          dir[2]  <= cfg_data[15:0];
        csit_pkg::REG_HALF_ANGLE_COS: hac     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  function automatic logic [1:0] shift_for(input logic [32:0] m);
    if (m[32]) return 2'd3;
    if (m[31]) return 2'd2;
    if (m[30]) return 2'd1;
    return 2'd0;
  endfunction

  // Stage 1: difference to the apex.
  logic               s1_valid;
  logic signed [32:0] s1_d [3];
  logic [30:0]        s1_r;

  // Stage 2: magnitudes and signs.
  logic               s2_valid;
  logic [32:0]        s2_mag [3];
  logic [2:0]         s2_neg;
  logic [30:0]        s2_r;
  logic               s2_zero;
  logic               s2_dirzero;

  // Stage 3: scaled components.
  logic               s3_valid;
  logic [29:0]        s3_m1 [3];
  logic signed [30:0] s3_dsc [3];
  logic [29:0]        s3_m2 [3];
  logic [29:0]        s3_r2;
  logic               s3_zero;
  logic               s3_dirzero;

  // Stage 4: products.
  logic               s4_valid;
  logic [59:0]        s4_sq1 [3];
  logic signed [46:0] s4_dp [3];
  logic [59:0]        s4_sq2 [3];
  logic [59:0]        s4_rr;
  logic               s4_zero;
  logic               s4_dirzero;

  // Stage 5: sums.
  logic               s5_valid;
  logic [61:0]        s5_sq1;
  logic signed [48:0] s5_dot;
  logic [61:0]        s5_sq2;
  logic [61:0]        s5_sqh;
  logic               s5_zero;
  logic               s5_dirzero;

  // Stage 6: magnitude of the dot product.
  logic               s6_valid;
  logic [61:0]        s6_sq1;
  logic [61:0]        s6_sq2;
  logic [61:0]        s6_sqh;
  csit_pkg::csit_side_a_t s6_side;

  logic [32:0]        mx1;
  logic [32:0]        mx2;
  logic [1:0]         sh1;
  logic [1:0]         sh2;
  logic [29:0]        m1_c [3];
  logic [29:0]        m2_c [3];
  logic [29:0]        r2_c;

  always_comb begin
    mx1 = s2_mag[0];
    if (s2_mag[1] > mx1) mx1 = s2_mag[1];
    if (s2_mag[2] > mx1) mx1 = s2_mag[2];
    mx2 = (33'(s2_r) > mx1) ? 33'(s2_r) : mx1;
    sh1 = shift_for(mx1);
    sh2 = shift_for(mx2);
    for (int i = 0; i < 3; i++) begin
      m1_c[i] = 30'(s2_mag[i] >> sh1);
      m2_c[i] = 30'(s2_mag[i] >> sh2);
    end
    r2_c = 30'(s2_r >> sh2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_d[0] <= 33'(sphere.center_x) - 33'(apex[0]);
    s1_d[1] <= 33'(sphere.center_y) - 33'(apex[1]);
    s1_d[2] <= 33'(sphere.center_z) - 33'(apex[2]);
    s1_r    <= sphere.radius;

    for (int i = 0; i < 3; i++) begin
      s2_mag[i] <= s1_d[i][32] ? 33'(-s1_d[i]) : 33'(s1_d[i]);
      s2_neg[i] <= s1_d[i][32];
    end
    s2_r       <= s1_r;
    s2_zero    <= (s1_d[0] == '0) && (s1_d[1] == '0) && (s1_d[2] == '0);
    s2_dirzero <= (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);

    for (int i = 0; i < 3; i++) begin
      s3_m1[i]  <= m1_c[i];
      s3_m2[i]  <= m2_c[i];
      s3_dsc[i] <= s2_neg[i] ? -$signed({1'b0, m1_c[i]}) : $signed({1'b0, m1_c[i]});
    end
    s3_r2      <= r2_c;
    s3_zero    <= s2_zero;
    s3_dirzero <= s2_dirzero;

    for (int i = 0; i < 3; i++) begin
      s4_sq1[i] <= 60'(s3_m1[i]) * 60'(s3_m1[i]);
      s4_sq2[i] <= 60'(s3_m2[i]) * 60'(s3_m2[i]);
      s4_dp[i]  <= 47'(dir[i]) * 47'(s3_dsc[i]);
    end
    s4_rr      <= 60'(s3_r2) * 60'(s3_r2);
    s4_zero    <= s3_zero;
    s4_dirzero <= s3_dirzero;

    s5_sq1     <= 62'(s4_sq1[0]) + 62'(s4_sq1[1]) + 62'(s4_sq1[2]);
    s5_sq2     <= 62'(s4_sq2[0]) + 62'(s4_sq2[1]) + 62'(s4_sq2[2]);
    s5_sqh     <= 62'(s4_sq2[0]) + 62'(s4_sq2[1]) + 62'(s4_sq2[2]) + 62'(s4_rr);
    s5_dot     <= 49'(s4_dp[0]) + 49'(s4_dp[1]) + 49'(s4_dp[2]);
    s5_zero    <= s4_zero;
    s5_dirzero <= s4_dirzero;

    s6_sq1         <= s5_sq1;
    s6_sq2         <= s5_sq2;
    s6_sqh         <= s5_sqh;
    s6_side.absdot <= s5_dot[48] ? 48'(-s5_dot) : 48'(s5_dot);
    s6_side.dotneg <= s5_dot[48];
    s6_side.zero   <= s5_zero;
    s6_side.dirzero <= s5_dirzero;
  end

  logic [RW-1:0] n1;
  logic [RW-1:0] n2;
  logic [RW-1:0] hyp;

  csit_isqrt #(.W(csit_pkg::SQ_IN_W)) u_sq_n1 (.clk(clk), .x(s6_sq1), .root(n1));
  csit_isqrt #(.W(csit_pkg::SQ_IN_W)) u_sq_n2 (.clk(clk), .x(s6_sq2), .root(n2));
  csit_isqrt #(.W(csit_pkg::SQ_IN_W)) u_sq_h  (.clk(clk), .x(s6_sqh), .root(hyp));

  logic                   a_valid;
  csit_pkg::csit_side_a_t a_side;

  csit_delay #(
    .W($bits(csit_pkg::csit_side_a_t)),
    .DEPTH(csit_pkg::SQ62_LAT)
  ) u_dly_a (
    .clk(clk), .rst(rst), .vin(s6_valid), .din(s6_side), .vout(a_valid), .dout(a_side)
  );

  logic [csit_pkg::Q14_BITS:0] cg_mag;
  logic [csit_pkg::Q14_BITS:0] cb_q;

  csit_div #(
    .NUM_W(csit_pkg::DIV_NUM_W), .DEN_W(RW), .QB(csit_pkg::Q14_BITS)
  ) u_div_cg (
    .clk(clk), .num(a_side.absdot), .den(n1), .quo(cg_mag)
  );

  csit_div #(
    .NUM_W(csit_pkg::DIV_NUM_W), .DEN_W(RW), .QB(csit_pkg::Q14_BITS)
  ) u_div_cb (
    .clk(clk),
    .num(csit_pkg::DIV_NUM_W'({n2, {csit_pkg::Q14_BITS{1'b0}}})),
    .den(hyp),
    .quo(cb_q)
  );

  csit_pkg::csit_side_b_t a_side_b;
  logic                   b_valid;
  csit_pkg::csit_side_b_t b_side;

  assign a_side_b.dotneg  = a_side.dotneg;
  assign a_side_b.zero    = a_side.zero;
  assign a_side_b.dirzero = a_side.dirzero;

  csit_delay #(
    .W($bits(csit_pkg::csit_side_b_t)),
    .DEPTH(csit_pkg::DIV_LAT)
  ) u_dly_b (
    .clk(clk), .rst(rst), .vin(a_valid), .din(a_side_b), .vout(b_valid), .dout(b_side)
  );

  // Stage 7: signed cos_gamma, clamped half-angle cosine and the sine operands.
  logic signed [15:0] ca_c;
  logic signed [31:0] ca_sq;
  logic [29:0]        cb_sq;

  always_comb begin
    if (hac > 16'sd16384) begin
      ca_c = 16'sd16384;
    end else if (hac < -16'sd16384) begin
      ca_c = -16'sd16384;
    end else begin
      ca_c = hac;
    end
    ca_sq = 32'(ca_c) * 32'(ca_c);
    cb_sq = 30'(cb_q) * 30'(cb_q);
  end

  logic                   s7_valid;
  csit_pkg::csit_side_c_t s7_side;
  logic [29:0]            s7_ta;
  logic [29:0]            s7_tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    s7_side.cg      <= b_side.dotneg ? -$signed({1'b0, cg_mag}) : $signed({1'b0, cg_mag});
    s7_side.ca      <= ca_c;
    s7_side.cb      <= cb_q;
    s7_side.zero    <= b_side.zero;
    s7_side.dirzero <= b_side.dirzero;
    s7_ta           <= 30'(32'(csit_pkg::ONE_Q14 * csit_pkg::ONE_Q14) - ca_sq);
    s7_tb           <= 30'(csit_pkg::ONE_Q14 * csit_pkg::ONE_Q14) - cb_sq;
  end

  logic [SW-1:0] sin_a;
  logic [SW-1:0] sin_b;

  csit_isqrt #(.W(csit_pkg::SIN_IN_W)) u_sq_sa (.clk(clk), .x(s7_ta), .root(sin_a));
  csit_isqrt #(.W(csit_pkg::SIN_IN_W)) u_sq_sb (.clk(clk), .x(s7_tb), .root(sin_b));

  logic                   c_valid;
  csit_pkg::csit_side_c_t c_side;

  csit_delay #(
    .W($bits(csit_pkg::csit_side_c_t)),
    .DEPTH(csit_pkg::SQ30_LAT)
  ) u_dly_c (
    .clk(clk), .rst(rst), .vin(s7_valid), .din(s7_side), .vout(c_valid), .dout(c_side)
  );

  // Stage 8: products of the final compare.
  logic               s8_valid;
  logic signed [31:0] s8_p1;
  logic [29:0]        s8_p2;
  logic signed [31:0] s8_lhs;
  logic               s8_early;
  logic               s8_zero;
  logic               s8_dirzero;
  logic signed [16:0] cos_sum;

  assign cos_sum = 17'(c_side.ca) + 17'($signed({1'b0, c_side.cb}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s8_valid <= c_valid;
      done     <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    s8_p1      <= 32'(c_side.ca) * 32'($signed({1'b0, c_side.cb}));
    s8_p2      <= 30'(sin_a) * 30'(sin_b);
    s8_lhs     <= 32'(c_side.cg) <<< csit_pkg::Q14_BITS;
    s8_early   <= (cos_sum <= 17'sd0);
    s8_zero    <= c_side.zero;
    s8_dirzero <= c_side.dirzero;

    result.hit <= s8_zero || s8_dirzero || s8_early ||
                  (s8_lhs >= (s8_p1 - $signed({2'b00, s8_p2})));
    result.apex_at_center <= s8_zero;
  end

endmodule
`default_nettype wire

@@ design/csit_isqrt.sv @@
`default_nettype none
module csit_isqrt #(
  parameter int W = csit_pkg::SQ_IN_W
) (
  input  logic           clk,
  input  logic [W-1:0]   x,
  output logic [W/2-1:0] root
);

  localparam int R  = W / 2;
  localparam int RW = R + 3;

  logic [W-1:0]  xs [R];
  logic [RW-1:0] rs [R];
  logic [R-1:0]  qs [R];
  logic [W-1:0]  xs_next [R];
  logic [RW-1:0] rs_next [R];
  logic [R-1:0]  qs_next [R];

  always_comb begin
    logic [W-1:0]  xp;
    logic [RW-1:0] rp;
    logic [RW-1:0] sh;
    logic [RW-1:0] tr;
    logic [R-1:0]  qp;
    for (int k = 0; k < R; k++) begin
      if (k == 0) begin
        xp = x;
        rp = '0;
        qp = '0;
      end else begin
        xp = xs[k-1];
        rp = rs[k-1];
        qp = qs[k-1];
      end
      sh = {rp[RW-3:0], xp[W-1:W-2]};
      tr = {1'b0, qp, 2'b01};
      xs_next[k] = {xp[W-3:0], 2'b00};
      if (sh >= tr) begin
        rs_next[k] = sh - tr;
        qs_next[k] = {qp[R-2:0], 1'b1};
      end else begin
        rs_next[k] = sh;
        qs_next[k] = {qp[R-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    xs <= xs_next;
    rs <= rs_next;
    qs <= qs_next;
  end

  assign root = qs[R-1];

endmodule
`default_nettype wire

@@ design/csit_div.sv @@
`default_nettype none
module csit_div #(
  parameter int NUM_W = csit_pkg::DIV_NUM_W,
  parameter int DEN_W = csit_pkg::SQ_IN_W / 2,
  parameter int QB    = csit_pkg::Q14_BITS
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QB:0]      quo
);

  localparam int S  = QB + 1;
  localparam int CW = NUM_W + 1;
  localparam logic [QB:0] QONE = {1'b1, {QB{1'b0}}};

  logic [NUM_W-1:0] rem [S];
  logic [DEN_W-1:0] dv [S];
  logic [QB-1:0]    qv [S];
  logic [S-1:0]     sat;
  logic [S-1:0]     zero;
  logic [NUM_W-1:0] rem_next [S];
  logic [DEN_W-1:0] dv_next [S];
  logic [QB-1:0]    qv_next [S];
  logic [S-1:0]     sat_next;
  logic [S-1:0]     zero_next;

  always_comb begin
    logic [CW-1:0] dext;
    logic [CW-1:0] shd;
    for (int k = 0; k < S; k++) begin
      dext = '0;
      shd  = '0;
      if (k == 0) begin
        dext         = CW'(den);
        rem_next[k]  = num;
        dv_next[k]   = den;
        qv_next[k]   = '0;
        zero_next[k] = (den == '0);
        sat_next[k]  = (den != '0) && ({1'b0, num} >= (dext << QB));
      end else begin
        dext         = CW'(dv[k-1]);
        shd          = dext << (QB - k);
        rem_next[k]  = rem[k-1];
        dv_next[k]   = dv[k-1];
        qv_next[k]   = qv[k-1];
        zero_next[k] = zero[k-1];
        sat_next[k]  = sat[k-1];
        if ({1'b0, rem[k-1]} >= shd) begin
          rem_next[k]       = rem[k-1] - shd[NUM_W-1:0];
          qv_next[k][QB-k]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    dv   <= dv_next;
    qv   <= qv_next;
    sat  <= sat_next;
    zero <= zero_next;
  end

  assign quo = zero[S-1] ? '0 : (sat[S-1] ? QONE : {1'b0, qv[S-1]});

endmodule
`default_nettype wire

@@ design/csit_delay.sv @@
`default_nettype none
module csit_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [DEPTH-1:0] v;
  logic [W-1:0]     d [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v[0] <= vin;
      for (int k = 1; k < DEPTH; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    d[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      d[k] <= d[k-1];
    end
  end

  assign vout = v[DEPTH-1];
  assign dout = d[DEPTH-1];

endmodule
`default_nettype wire

@@ design/csit_checker.sv @@
`default_nettype none
`include "cone_sphere_intersect_test_assert.svh"
module csit_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input csit_pkg::csit_out_t result
);

  // Every accepted sphere yields its transfer after the fixed latency.
  `CSIT_ASSERT_DLY(a_latency, clk, rst, start && !busy, csit_pkg::PIPE_LAT, done)

  // No transfer appears without a sphere accepted the fixed latency before.
  `CSIT_ASSERT_IMP(a_no_spurious, clk, rst, done, $past(start && !busy, csit_pkg::PIPE_LAT))

  // A centre at the apex always counts as a hit.
  `CSIT_ASSERT_IMP(a_apex_hit, clk, rst, done && result.apex_at_center, result.hit)

endmodule

bind cone_sphere_intersect_test csit_checker u_csit_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .result(result)
);
`default_nettype wire
